// ===== src/kdlnp_pkg.sv =====
`default_nettype none
package kdlnp_pkg;

   // Matrix size and held-key stack depth.
   localparam int NUM_COLUMNS = 8;
   localparam int NUM_ROWS    = 6;
   localparam int STACK_DEPTH = 48;

   // Field widths fixed by the interface.
   localparam int COL_W  = 3;
   localparam int ROW_W  = 3;
   localparam int KEY_W  = COL_W + ROW_W;
   localparam int THR_W  = 8;
   localparam int STEP_W = 28;

   // Per-key state is addressed by the packed {column, row} code.
   localparam int KEY_SLOTS = 1 << KEY_W;
   localparam int KST_W     = THR_W + 1;

   // Held-key stack addressing and fill count.
   localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int STK_CW = $clog2(STACK_DEPTH + 1);

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(20);

   // Oscillator phase increments, indexed by column and then row.
   localparam int ROM_COLS = 8;
   localparam int ROM_ROWS = 6;
   localparam logic [STEP_W-1:0] STEP_ROM [ROM_COLS][ROM_ROWS] = '{
      '{28'd15624207, 28'd24801882, 28'd39370534, 28'd62496826, 28'd99207528, 28'd157482134},
      '{28'd16553270, 28'd26276679, 28'd41711627, 28'd66213081, 28'd105106715, 28'd166846509},
      '{28'd17537579, 28'd27839171, 28'd44191930, 28'd70150316, 28'd111356685, 28'd176767719},
      '{28'd18580418, 28'd29494575, 28'd46819719, 28'd74321671, 28'd117978298, 28'd187278874},
      '{28'd19685267, 28'd31248413, 28'd49603764, 28'd78741067, 28'd124993653, 28'd198415056},
      '{28'd20855814, 28'd33106541, 28'd52553357, 28'd83423255, 28'd132426162, 28'd210213429},
      '{28'd22095965, 28'd35075158, 28'd55678342, 28'd88383859, 28'd140300631, 28'd222713370},
      '{28'd23409859, 28'd37160835, 28'd58989149, 28'd93639437, 28'd148643341, 28'd235956596}
   };

   function automatic logic [STEP_W-1:0] rom_step(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      logic [STEP_W-1:0] step;
      step = '0;
      if (int'(col) < ROM_COLS && int'(row) < ROM_ROWS) begin
         step = STEP_ROM[col][row];
      end
      return step;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EVAL,
      ST_SCAN,
      ST_POP,
      ST_TOP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic key_read;
      logic key_eval;
      logic scan_step;
      logic pop_check;
      logic take_top;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic release_flip;
      logic scan_done;
      logic pop_retrig;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ===== src/kdlnp_ram.sv =====
`default_nettype none
module kdlnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/kdlnp_ctrl.sv =====
`default_nettype none
module kdlnp_ctrl
   import kdlnp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_EVAL;
         ST_EVAL: state_in = status.release_flip ? ST_SCAN : ST_DONE;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_POP;
            end
         end
         ST_POP:  state_in = status.pop_retrig ? ST_TOP : ST_DONE;
         ST_TOP:  state_in = ST_DONE;
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_LOAD: cmd.key_read  = 1'b1;
         ST_EVAL: cmd.key_eval  = 1'b1;
         ST_SCAN: cmd.scan_step = 1'b1;
         ST_POP:  cmd.pop_check = 1'b1;
         ST_TOP:  cmd.take_top  = 1'b1;
         ST_DONE: cmd.load_rsp  = status.rsp_free;
         default: req_stall = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/kdlnp_dp.sv =====
`default_nettype none
module kdlnp_dp
   import kdlnp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output      status_type        status,
   input  wire logic [COL_W-1:0]  req_key_column,
   input  wire logic [ROW_W-1:0]  req_key_row,
   input  wire logic              req_key_level,
   input  wire logic              csr_valid,
   input  wire logic [THR_W-1:0]  csr_debounce_threshold,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_note_on,
   output      logic              rsp_release_pulse,
   output      logic              rsp_active_valid,
   output      logic [COL_W-1:0]  rsp_active_column,
   output      logic [ROW_W-1:0]  rsp_active_row,
   output      logic [STEP_W-1:0] rsp_phase_step
);

   // Control state.
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [KEY_SLOTS-1:0] kvld_ff, kvld_in;
   logic [STK_CW-1:0]    count_ff, count_in;
   logic [KEY_W-1:0]     active_ff, active_in;
   logic                 flag_ff, flag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 pend_ff, pend_in;

   // Per-item working registers.
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 level_ff, level_in;
   logic                 note_ff, note_in;
   logic                 rel_ff, rel_in;
   logic [STK_CW-1:0]    scan_idx_ff, scan_idx_in;
   logic [STK_AW-1:0]    pos_ff, pos_in;
   logic                 found_ff, found_in;

   // Result registers.
   logic                 o_note_ff, o_note_in;
   logic                 o_rel_ff, o_rel_in;
   logic                 o_act_ff, o_act_in;
   logic [COL_W-1:0]     o_col_ff, o_col_in;
   logic [ROW_W-1:0]     o_row_ff, o_row_in;
   logic [STEP_W-1:0]    o_step_ff, o_step_in;

   // Memory ports.
   logic                 kst_wr_en;
   logic [KST_W-1:0]     kst_wr_data;
   logic [KST_W-1:0]     kst_rd_data;
   logic                 stk_wr_en;
   logic [STK_AW-1:0]    stk_wr_addr;
   logic [KEY_W-1:0]     stk_wr_data;
   logic                 stk_rd_en;
   logic [STK_AW-1:0]    stk_rd_addr;
   logic [KEY_W-1:0]     stk_rd_data;

   logic [KEY_W-1:0]     key;
   logic                 in_matrix;
   logic                 cur_lvl;
   logic [THR_W-1:0]     cur_cnt;
   logic [THR_W-1:0]     cnt_inc;
   logic                 differ;
   logic                 flip;
   logic                 scan_issue;
   logic                 hit_active;

   assign key       = {col_ff, row_ff};
   assign in_matrix = (int'(col_ff) < NUM_COLUMNS) && (int'(row_ff) < NUM_ROWS);
   assign cur_lvl   = kvld_ff[key] ? kst_rd_data[KST_W-1] : 1'b0;
   assign cur_cnt   = kvld_ff[key] ? kst_rd_data[THR_W-1:0] : '0;
   assign cnt_inc   = cur_cnt + THR_W'(1);
   assign differ    = level_ff != cur_lvl;
   assign flip      = differ && (cnt_inc >= thr_ff);
   assign scan_issue = scan_idx_ff < count_ff;
   assign hit_active = flag_ff && (active_ff == key);

   assign status.release_flip = in_matrix && flip && !level_ff;
   assign status.scan_done    = !pend_ff && !scan_issue;
   assign status.pop_retrig   = hit_active && (count_ff != '0);
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

   kdlnp_ram #(
      .WIDTH(KST_W),
      .DEPTH(KEY_SLOTS)
   ) u_key_state (
      .clock  (clock),
      .wr_en  (kst_wr_en),
      .wr_addr(key),
      .wr_data(kst_wr_data),
      .rd_en  (cmd.key_read),
      .rd_addr(key),
      .rd_data(kst_rd_data)
   );

   kdlnp_ram #(
      .WIDTH(KEY_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (stk_wr_en),
      .wr_addr(stk_wr_addr),
      .wr_data(stk_wr_data),
      .rd_en  (stk_rd_en),
      .rd_addr(stk_rd_addr),
      .rd_data(stk_rd_data)
   );

   always_comb begin
      thr_in       = thr_ff;
      kvld_in      = kvld_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_in      = pend_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      level_in     = level_ff;
      note_in      = note_ff;
      rel_in       = rel_ff;
      scan_idx_in  = scan_idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      o_note_in    = o_note_ff;
      o_rel_in     = o_rel_ff;
      o_act_in     = o_act_ff;
      o_col_in     = o_col_ff;
      o_row_in     = o_row_ff;
      o_step_in    = o_step_ff;

      kst_wr_en   = 1'b0;
      kst_wr_data = {cur_lvl, THR_W'(0)};
      stk_wr_en   = 1'b0;
      stk_wr_addr = count_ff[STK_AW-1:0];
      stk_wr_data = key;
      stk_rd_en   = 1'b0;
      stk_rd_addr = scan_idx_ff[STK_AW-1:0];

      if (csr_valid) begin
         thr_in = csr_debounce_threshold;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.capture) begin
         col_in   = req_key_column;
         row_in   = req_key_row;
         level_in = req_key_level;
         note_in  = 1'b0;
         rel_in   = 1'b0;
      end

      if (cmd.key_eval) begin
         scan_idx_in = '0;
         pend_in     = 1'b0;
         found_in    = 1'b0;
         if (in_matrix) begin
            kst_wr_en    = 1'b1;
            kvld_in[key] = 1'b1;
            if (!differ) begin
               kst_wr_data = {cur_lvl, THR_W'(0)};
            end else if (flip) begin
               kst_wr_data = {level_ff, THR_W'(0)};
               if (level_ff) begin
                  // Press: push when there is room, and the key becomes active anyway.
                  if (int'(count_ff) < STACK_DEPTH) begin
                     stk_wr_en = 1'b1;
                     count_in  = count_ff + STK_CW'(1);
                  end
                  active_in = key;
                  flag_in   = 1'b1;
                  note_in   = 1'b1;
               end
            end else begin
               kst_wr_data = {cur_lvl, cnt_inc};
            end
         end
      end

      if (cmd.scan_step) begin
         // One read issued per cycle; the entry read in the previous cycle is checked now.
         if (scan_issue) begin
            stk_rd_en   = 1'b1;
            scan_idx_in = scan_idx_ff + STK_CW'(1);
            pos_in      = scan_idx_ff[STK_AW-1:0];
         end
         pend_in = scan_issue;
         if (pend_ff) begin
            if (found_ff) begin
               // Entries above the removed key move down by one place.
               stk_wr_en   = 1'b1;
               stk_wr_addr = pos_ff - STK_AW'(1);
               stk_wr_data = stk_rd_data;
            end else if (stk_rd_data == key) begin
               found_in = 1'b1;
            end
         end
         if (!pend_ff && !scan_issue && found_ff) begin
            count_in = count_ff - STK_CW'(1);
         end
      end

      if (cmd.pop_check && hit_active) begin
         if (count_ff != '0) begin
            stk_rd_en   = 1'b1;
            stk_rd_addr = STK_AW'(count_ff - STK_CW'(1));
         end else begin
            flag_in   = 1'b0;
            active_in = '0;
            rel_in    = 1'b1;
         end
      end

      if (cmd.take_top) begin
         active_in = stk_rd_data;
         note_in   = 1'b1;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         o_note_in    = note_ff;
         o_rel_in     = rel_ff;
         o_act_in     = flag_ff;
         o_col_in     = flag_ff ? active_ff[KEY_W-1:ROW_W] : '0;
         o_row_in     = flag_ff ? active_ff[ROW_W-1:0] : '0;
         o_step_in    = flag_ff ? rom_step(active_ff[KEY_W-1:ROW_W], active_ff[ROW_W-1:0])
                                : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         kvld_ff      <= '0;
         count_ff     <= '0;
         active_ff    <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         kvld_ff      <= kvld_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      level_ff    <= level_in;
      note_ff     <= note_in;
      rel_ff      <= rel_in;
      scan_idx_ff <= scan_idx_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      o_note_ff   <= o_note_in;
      o_rel_ff    <= o_rel_in;
      o_act_ff    <= o_act_in;
      o_col_ff    <= o_col_in;
      o_row_ff    <= o_row_in;
      o_step_ff   <= o_step_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_note_on       = o_note_ff;
   assign rsp_release_pulse = o_rel_ff;
   assign rsp_active_valid  = o_act_ff;
   assign rsp_active_column = o_col_ff;
   assign rsp_active_row    = o_row_ff;
   assign rsp_phase_step    = o_step_ff;

endmodule
`default_nettype wire

// ===== src/key_debounce_last_note_priority_unit.sv =====
`default_nettype none
// Debounces one raw sample of one key of an 8 x 6 key matrix per transfer and tracks the
// held keys with last-note priority. Each sample returns exactly one result transfer that
// reports note_on, release_pulse and the currently active key with its oscillator phase
// step. A sample that only moves the debounce counter or presses a key goes through the
// load, evaluate and done states. A debounced release scans the held-key stack through
// a RAM with one read and one write port, one entry per cycle while closing the gap
// behind it, then checks the active key and reads the top of the stack when a held key
// is retriggered. The last step waits while an older result is still stalled in the
// output register. The block accepts one sample at a time; a finished result may wait in
// the output register while the next sample is accepted.
// The debounce threshold register may be written at any time the block is idle; a
// threshold of zero acts like one.
module key_debounce_last_note_priority_unit
   import kdlnp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Sample input channel.
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [COL_W-1:0]  req_key_column,
   input  wire logic [ROW_W-1:0]  req_key_row,
   input  wire logic              req_key_level,
   // Threshold write channel.
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [THR_W-1:0]  csr_debounce_threshold,
   // Result channel.
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_note_on,
   output      logic              rsp_release_pulse,
   output      logic              rsp_active_valid,
   output      logic [COL_W-1:0]  rsp_active_column,
   output      logic [ROW_W-1:0]  rsp_active_row,
   output      logic [STEP_W-1:0] rsp_phase_step
);

   cmd_type    cmd;
   status_type status;

   // The threshold register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // The controller steps each sample through key lookup, update, a stack scan on a debounced release, and result.
   kdlnp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds per-key debounce state, the held-key stack and the result register.
   kdlnp_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_key_column        (req_key_column),
      .req_key_row           (req_key_row),
      .req_key_level         (req_key_level),
      .csr_valid             (csr_valid),
      .csr_debounce_threshold(csr_debounce_threshold),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_note_on           (rsp_note_on),
      .rsp_release_pulse     (rsp_release_pulse),
      .rsp_active_valid      (rsp_active_valid),
      .rsp_active_column     (rsp_active_column),
      .rsp_active_row        (rsp_active_row),
      .rsp_phase_step        (rsp_phase_step)
   );

endmodule
`default_nettype wire

// ===== tb/note_priority_checker.sv =====
`timescale 1ns / 100ps
module note_priority_checker
   import kdlnp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [COL_W-1:0]  req_key_column,
   input  wire logic [ROW_W-1:0]  req_key_row,
   input  wire logic              req_key_level,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [THR_W-1:0]  csr_debounce_threshold,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_note_on,
   input  wire logic              rsp_release_pulse,
   input  wire logic              rsp_active_valid,
   input  wire logic [COL_W-1:0]  rsp_active_column,
   input  wire logic [ROW_W-1:0]  rsp_active_row,
   input  wire logic [STEP_W-1:0] rsp_phase_step,
   output int                     outstanding,
   output int                     mismatch_count
);

   localparam int NUM_KEYS = NUM_COLUMNS * NUM_ROWS;

   typedef struct {
      logic              note_on;
      logic              release_pulse;
      logic              active_valid;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [STEP_W-1:0] step;
   } note_result_type;

   // Shadow of the key state: debounced levels, change counters, held-key stack.
   logic             key_level_q [NUM_KEYS];
   logic [THR_W-1:0] change_cnt  [NUM_KEYS];
   int               held_stack  [STACK_DEPTH];
   int               held_n;
   int               lead_key;
   logic             lead_on;
   logic [THR_W-1:0] threshold;
   note_result_type  expected_notes [$];

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   // Applies one raw sample to the shadow state and returns the result it causes.
   function automatic note_result_type advance_keys(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic lvl);
      note_result_type res;
      int key;
      int k;
      int m;
      res = '{default: '0};
      if (int'(col) < NUM_COLUMNS && int'(row) < NUM_ROWS) begin
         key = int'(col) * NUM_ROWS + int'(row);
         if (lvl != key_level_q[key]) begin
            change_cnt[key] = change_cnt[key] + 1'b1;
            if (change_cnt[key] >= threshold) begin
               key_level_q[key] = lvl;
               change_cnt[key]  = '0;
               if (lvl) begin
                  if (held_n < STACK_DEPTH) begin
                     held_stack[held_n] = key;
                     held_n++;
                  end
                  lead_key    = key;
                  lead_on     = 1'b1;
                  res.note_on = 1'b1;
               end else begin
                  for (k = 0; k < held_n; k++) begin
                     if (held_stack[k] == key) begin
                        for (m = k; m + 1 < held_n; m++) begin
                           held_stack[m] = held_stack[m + 1];
                        end
                        held_n--;
                        break;
                     end
                  end
                  if (lead_on && lead_key == key) begin
                     if (held_n > 0) begin
                        lead_key    = held_stack[held_n - 1];
                        res.note_on = 1'b1;
                     end else begin
                        lead_on           = 1'b0;
                        lead_key          = 0;
                        res.release_pulse = 1'b1;
                     end
                  end
               end
            end
         end else begin
            change_cnt[key] = '0;
         end
      end
      res.active_valid = lead_on;
      if (lead_on) begin
         res.column = COL_W'(lead_key / NUM_ROWS);
         res.row    = ROW_W'(lead_key % NUM_ROWS);
         res.step   = STEP_ROM[lead_key / NUM_ROWS][lead_key % NUM_ROWS];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      note_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_level_q[i] = 1'b0;
            change_cnt[i]  = '0;
         end
         held_n         = 0;
         lead_key       = 0;
         lead_on        = 1'b0;
         threshold      = THRESHOLD_RESET;
         mismatch_count = 0;
         expected_notes.delete();
      end else begin
         // Results are matched before the new sample is queued, so a result that
         // arrives with nothing pending is never paired with a fresh sample.
         if (rsp_valid && !rsp_stall) begin
            if (expected_notes.size() == 0) begin
               report_mismatch("result transfer with no sample pending");
            end else begin
               want = expected_notes.pop_front();
               check_field("note_on", 32'(rsp_note_on), 32'(want.note_on));
               check_field("release_pulse", 32'(rsp_release_pulse), 32'(want.release_pulse));
               check_field("active_valid", 32'(rsp_active_valid), 32'(want.active_valid));
               check_field("active_column", 32'(rsp_active_column), 32'(want.column));
               check_field("active_row", 32'(rsp_active_row), 32'(want.row));
               check_field("phase_step", 32'(rsp_phase_step), 32'(want.step));
            end
         end
         if (csr_valid && csr_ready) begin
            threshold = csr_debounce_threshold;
         end
         if (req_valid && !req_stall) begin
            expected_notes.push_back(advance_keys(req_key_column, req_key_row,
                                                  req_key_level));
         end
      end
      outstanding <= expected_notes.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
   import kdlnp_pkg::*;

   // Timeout in clock cycles. The slowest legal run (every sample a full-stack
   // release, every gap and stall at its longest) stays well below this.
   localparam int CYCLE_LIMIT  = 1000000;
   // Number of in-matrix samples the random part aims for.
   localparam int SAMPLE_GOAL  = 1750;
   // Cycles to wait after the last result, covering the longest release scan.
   localparam int DRAIN_CYCLES = 64;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [COL_W-1:0]  req_key_column = '0;
   logic [ROW_W-1:0]  req_key_row = '0;
   logic              req_key_level = 1'b0;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [THR_W-1:0]  csr_debounce_threshold = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_note_on;
   logic              rsp_release_pulse;
   logic              rsp_active_valid;
   logic [COL_W-1:0]  rsp_active_column;
   logic [ROW_W-1:0]  rsp_active_row;
   logic [STEP_W-1:0] rsp_phase_step;

   int               outstanding;
   int               mismatch_count;
   int               samples_sent = 0;
   int               cycle_count = 0;
   int               stall_left = 0;
   // Threshold the stimulus believes is programmed; it only sizes the sample runs.
   logic [THR_W-1:0] thr_now = THRESHOLD_RESET;
   // When set, neither side idles, giving back-to-back stretches.
   logic             steady_phase = 1'b0;

   always #2 clock = ~clock;

   key_debounce_last_note_priority_unit i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_key_column         (req_key_column),
      .req_key_row            (req_key_row),
      .req_key_level          (req_key_level),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_debounce_threshold (csr_debounce_threshold),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_note_on            (rsp_note_on),
      .rsp_release_pulse      (rsp_release_pulse),
      .rsp_active_valid       (rsp_active_valid),
      .rsp_active_column      (rsp_active_column),
      .rsp_active_row         (rsp_active_row),
      .rsp_phase_step         (rsp_phase_step)
   );

   note_priority_checker i_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_key_column         (req_key_column),
      .req_key_row            (req_key_row),
      .req_key_level          (req_key_level),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_debounce_threshold (csr_debounce_threshold),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_note_on            (rsp_note_on),
      .rsp_release_pulse      (rsp_release_pulse),
      .rsp_active_valid       (rsp_active_valid),
      .rsp_active_column      (rsp_active_column),
      .rsp_active_row         (rsp_active_row),
      .rsp_phase_step         (rsp_phase_step),
      .outstanding            (outstanding),
      .mismatch_count         (mismatch_count)
   );

   // The run is ended here if it hangs, for example when a result never shows up.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result-side back pressure. Most cycles take the result at once, some stall
   // for a few cycles and now and then a long stall holds a finished result in
   // the output register while the block sits on it.
   always @(posedge clock) begin
      int pick;
      if (stall_left > 0) begin
         stall_left--;
      end else if (!steady_phase) begin
         pick = $urandom_range(0, 63);
         if (pick < 10) begin
            stall_left = $urandom_range(1, 3);
         end else if (pick == 10) begin
            stall_left = $urandom_range(10, 40);
         end
      end
      rsp_stall <= (stall_left > 0);
   end

   // Idle cycles before a sample transfer: mostly none, some short, a few long.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 63);
      if (steady_phase || pick < 40) begin
         return 0;
      end else if (pick < 62) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Offers one sample and holds it until the block takes the transfer. Valid is
   // only lowered when a gap follows, so it is never dropped and raised in the
   // same time step.
   task automatic send_sample(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic lvl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_column <= col;
      req_key_row    <= row;
      req_key_level  <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Samples outside the matrix are ignored by the block and do not count.
      if (int'(row) < NUM_ROWS) begin
         samples_sent++;
      end
   endtask

   // Drops valid and waits until every sample has produced its result. The first
   // edge lets the checker account for a sample accepted in this very step. Every
   // sample yields a result, so the block is idle once nothing is outstanding.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      wait_idle();
      csr_valid              <= 1'b1;
      csr_debounce_threshold <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      thr_now = value;
   endtask

   // A clean run of identical samples, just long enough to flip a key that
   // currently sits at the other level. A zero threshold acts like one.
   task automatic drive_level(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic lvl);
      int run;
      run = (thr_now == 0) ? 1 : int'(thr_now);
      repeat (run) send_sample(col, row, lvl);
   endtask

   initial begin
      int               phase_len;
      int               phase_count;
      int               press_bias;
      int               pick;
      int               key;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             lvl;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With the reset threshold a single differing sample only
      // moves the counter, an agreeing one clears it, and keys outside the matrix
      // are ignored.
      send_sample(3'd0, 3'd0, 1'b1);
      send_sample(3'd0, 3'd0, 1'b0);
      send_sample(3'd3, 3'd6, 1'b1);
      send_sample(3'd7, 3'd7, 1'b1);

      // Threshold one: press the lowest and the highest key, then a third one.
      write_threshold(8'd1);
      send_sample(3'd0, 3'd0, 1'b1);
      send_sample(3'd7, 3'd5, 1'b1);
      send_sample(3'd3, 3'd2, 1'b1);
      // Release of a held key that is not active closes the gap in the stack.
      send_sample(3'd7, 3'd5, 1'b0);
      // An agreeing sample and an out-of-matrix sample only report the active key.
      send_sample(3'd0, 3'd0, 1'b1);
      send_sample(3'd2, 3'd6, 1'b1);
      // Releasing the active key retriggers the newest held key, and releasing
      // the last held key gives the release pulse.
      send_sample(3'd3, 3'd2, 1'b0);
      send_sample(3'd0, 3'd0, 1'b0);
      send_sample(3'd1, 3'd1, 1'b0);

      // A zero threshold flips on the first differing sample.
      write_threshold(8'd0);
      send_sample(3'd5, 3'd3, 1'b1);
      send_sample(3'd5, 3'd3, 1'b0);

      // Threshold two with contact bounce: the opposite sample clears the count.
      write_threshold(8'd2);
      send_sample(3'd4, 3'd4, 1'b1);
      send_sample(3'd4, 3'd4, 1'b0);
      send_sample(3'd4, 3'd4, 1'b1);
      send_sample(3'd4, 3'd4, 1'b1);
      send_sample(3'd4, 3'd4, 1'b0);
      send_sample(3'd4, 3'd4, 1'b0);

      // Largest threshold: the counter climbs all the way before the flip.
      write_threshold(8'd255);
      drive_level(3'd6, 3'd1, 1'b1);
      send_sample(3'd6, 3'd1, 1'b0);

      // Fill the whole stack, then release in a scattered order so the scan and
      // the gap closing run over every depth, with retriggers along the way.
      write_threshold(8'd1);
      send_sample(3'd6, 3'd1, 1'b1);
      for (int k = 0; k < NUM_COLUMNS * NUM_ROWS; k++) begin
         send_sample(COL_W'(k / NUM_ROWS), ROW_W'(k % NUM_ROWS), 1'b1);
      end
      for (int k = 0; k < NUM_COLUMNS * NUM_ROWS; k++) begin
         key = (k * 5 + 7) % (NUM_COLUMNS * NUM_ROWS);
         send_sample(COL_W'(key / NUM_ROWS), ROW_W'(key % NUM_ROWS), 1'b0);
      end

      // Random phases. Each picks a threshold, a press/release balance and
      // whether the handshakes idle. Most traffic is clean runs that flip keys,
      // the rest is bounce, single noisy samples and runs cut short.
      phase_count = 0;
      while (samples_sent < SAMPLE_GOAL) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            write_threshold(8'd0);
         end else if (pick <= 5) begin
            write_threshold(THR_W'($urandom_range(1, 3)));
         end else if (pick <= 8) begin
            write_threshold(THR_W'($urandom_range(4, 12)));
         end else begin
            write_threshold(THR_W'($urandom_range(13, 40)));
         end
         steady_phase <= ($urandom_range(0, 3) == 0);
         press_bias = (phase_count % 2 == 0) ? $urandom_range(55, 90) : $urandom_range(15, 50);
         phase_len  = samples_sent + $urandom_range(100, 200);
         // The last phase stops at the overall sample goal.
         if (phase_len > SAMPLE_GOAL) begin
            phase_len = SAMPLE_GOAL;
         end
         phase_count++;
         while (samples_sent < phase_len) begin
            col  = COL_W'($urandom_range(0, NUM_COLUMNS - 1));
            row  = ROW_W'($urandom_range(0, NUM_ROWS - 1));
            lvl  = ($urandom_range(0, 99) < press_bias);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               // Sometimes the contact bounces before it settles.
               if ($urandom_range(0, 3) == 0) begin
                  send_sample(col, row, lvl);
                  send_sample(col, row, !lvl);
               end
               drive_level(col, row, lvl);
            end else if (pick < 9) begin
               // Noise anywhere in the field ranges, off-matrix rows included.
               send_sample(COL_W'($urandom_range(0, 7)), ROW_W'($urandom_range(0, 7)),
                           1'($urandom_range(0, 1)));
            end else if (thr_now > 1) begin
               // A run one or more samples short, broken by the opposite level.
               repeat ($urandom_range(1, int'(thr_now) - 1)) send_sample(col, row, lvl);
               send_sample(col, row, !lvl);
            end else begin
               send_sample(col, row, lvl);
            end
         end
      end

      // All samples are in: wait for the last results, then give any stray
      // transfer time to show up before the verdict.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
